@@ hdl/tsag_pkg.sv @@
`timescale 1ns / 1ps

package tsag_pkg;

  // default sizes
  localparam int TEX_BITS_DEF = 20;
  localparam int MAX_SPAN_DEF = 64;

  // fixed field widths
  localparam int ACC_W      = 32;
  localparam int WHOLE_W    = 16;
  localparam int OFS_W      = 23;
  localparam int CNT_IN_W   = 7;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 136;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int LOG_W    = 5;
  localparam int HEIGHT_W = 12;
  localparam int STRIDE_W = 16;

  // register reset values
  localparam logic [LOG_W-1:0]    LOG_U_RST      = 5'd6;
  localparam logic [LOG_W-1:0]    LOG_V_RST      = 5'd6;
  localparam logic [LOG_W-1:0]    VERT_SHIFT_RST = 5'd26;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST     = 12'd64;
  localparam logic [STRIDE_W-1:0] STRIDE_RST     = 16'd320;

  typedef enum logic [OP_W-1:0] {
    OP_HLINE_DESC = 2'd0,
    OP_HLINE_ASC  = 2'd1,
    OP_VLINE      = 2'd2,
    OP_SPRITE     = 2'd3
  } span_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOG_U         = 3'd0,
    REG_LOG_V         = 3'd1,
    REG_VERT_SHIFT    = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_DEST_STRIDE   = 3'd4
  } cfg_reg_t;

  // settings seen by the index unit
  typedef struct packed {
    logic [LOG_W-1:0]    log_u;
    logic [LOG_W-1:0]    log_v;
    logic [LOG_W-1:0]    vert_shift;
    logic [HEIGHT_W-1:0] sprite_height;
  } tex_cfg_t;

endpackage

@@ hdl/tsag_texel_unit.sv @@
`timescale 1ns / 1ps

module tsag_texel_unit #(
  parameter int TEX_BITS = tsag_pkg::TEX_BITS_DEF
) (
  input  tsag_pkg::tex_cfg_t         cfg,
  input  tsag_pkg::span_op_t         kind,
  input  logic [tsag_pkg::ACC_W-1:0] u_acc,
  input  logic [tsag_pkg::ACC_W-1:0] v_acc,
  output logic [TEX_BITS-1:0]        texel
);
  import tsag_pkg::*;

  localparam int PROD_W = WHOLE_W + HEIGHT_W + 1;

  logic [LOG_W-1:0]         u_sh;
  logic [LOG_W-1:0]         v_sh;
  logic [ACC_W-1:0]         u_top;
  logic [ACC_W-1:0]         v_top;
  logic [ACC_W-1:0]         hline_idx;
  logic [ACC_W-1:0]         vline_idx;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         sprite_idx;
  logic [ACC_W-1:0]         idx;

  // 32 - log as a 5-bit shift, valid for log in 1..31
  assign u_sh  = LOG_W'(0) - cfg.log_u;
  assign v_sh  = LOG_W'(0) - cfg.log_v;
  assign u_top = (cfg.log_u == '0) ? '0 : (u_acc >> u_sh);
  assign v_top = (cfg.log_v == '0) ? '0 : (v_acc >> v_sh);

  assign hline_idx = (u_top << cfg.log_v) + v_top;
  assign vline_idx = v_acc >> cfg.vert_shift;

  // signed whole part of u times column height, plus signed whole part of v
  assign prod = PROD_W'($signed(u_acc[ACC_W-1 -: WHOLE_W]))
              * PROD_W'($signed({1'b0, cfg.sprite_height}));
  assign sprite_idx = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod}
                    + {{(ACC_W-WHOLE_W){v_acc[ACC_W-1]}}, v_acc[ACC_W-1 -: WHOLE_W]};

  always_comb begin
    unique case (kind)
      OP_HLINE_DESC, OP_HLINE_ASC: idx = hline_idx;
      OP_VLINE:                    idx = vline_idx;
      OP_SPRITE:                   idx = sprite_idx;
      default:                     idx = sprite_idx;
    endcase
  end

  assign texel = idx[TEX_BITS-1:0];

endmodule

@@ hdl/textured_span_address_generator_unit.sv @@
`timescale 1ns / 1ps

// channel  | dir | handshake                  | contents
// ---------+-----+----------------------------+-------------------------------------------
// cfg      | in  | cfg_we                     | cfg_index, cfg_value (register write)
// s_axis   | in  | s_tvalid / s_tready        | tuser op; tdata u/v start, u/v step, count
// m_axis   | out | m_tvalid / m_tready        | tdata texel index, pixel offset; tlast
//
// a span of n pixels (n saturated to MAX_SPAN) holds the input until its last pixel
// is loaded: one pixel per cycle from the shared index unit and the step adders,
// pausing on stalls; the first pixel is valid after the state and output registers
// s_tready is high only between spans; a zero-pixel span is taken without leaving idle
// the output register holds a pixel while m_tready is low and the span pauses
// rst is synchronous and returns the registers to their defaults and the block to idle

module textured_span_address_generator_unit #(
  parameter int TEX_BITS = tsag_pkg::TEX_BITS_DEF,
  parameter int MAX_SPAN = tsag_pkg::MAX_SPAN_DEF,
  localparam int OUT_W = ((TEX_BITS + tsag_pkg::OFS_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tsag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsag_pkg::CFG_DATA_W-1:0] cfg_value,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // u_start, v_start, u_step, v_step, pixel_count, zero pad
  input  logic [tsag_pkg::IN_DATA_W-1:0]  s_tdata,
  // op
  input  logic [tsag_pkg::OP_W-1:0]       s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // texel_index, pixel_offset, zero pad
  output logic [OUT_W-1:0]                m_tdata,
  output logic                            m_tlast
);
  import tsag_pkg::*;

  localparam int CNT_W = $clog2(MAX_SPAN + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state;

  // configuration registers
  logic [LOG_W-1:0]    log_u;
  logic [LOG_W-1:0]    log_v;
  logic [LOG_W-1:0]    vert_shift;
  logic [HEIGHT_W-1:0] sprite_height;
  logic [STRIDE_W-1:0] dest_stride;
  tex_cfg_t            tex_cfg;

  // span state
  span_op_t         kind;
  logic [ACC_W-1:0] u_acc;
  logic [ACC_W-1:0] v_acc;
  logic [ACC_W-1:0] u_inc;
  logic [ACC_W-1:0] v_inc;
  logic [CNT_W-1:0] pix_left;
  logic [OFS_W-1:0] pix_pos;

  logic [ACC_W-1:0] u_acc_next;
  logic [ACC_W-1:0] v_acc_next;
  logic [OFS_W-1:0] pix_pos_next;

  // output register
  logic                out_valid;
  logic [TEX_BITS-1:0] out_texel;
  logic [OFS_W-1:0]    out_pos;
  logic                out_last;

  logic                texel;
  logic [TEX_BITS-1:0] texel_idx;
  logic                start;
  logic                load;
  logic                last_pix;
  logic [CNT_IN_W-1:0] in_cnt;
  logic [CNT_W-1:0]    start_cnt;

  // input item fields
  assign in_cnt = s_tdata[4*ACC_W +: CNT_IN_W];
  assign start_cnt = (in_cnt > CNT_IN_W'(MAX_SPAN)) ? CNT_W'(MAX_SPAN) : CNT_W'(in_cnt);

  assign s_tready = (state == ST_IDLE);
  assign start    = s_tvalid && s_tready;

  // a pixel moves into the output register when it is empty or being drained
  assign load     = (state == ST_RUN) && (!out_valid || m_tready);
  assign last_pix = (pix_left == CNT_W'(1));
  assign texel    = load;

  assign tex_cfg = '{log_u: log_u, log_v: log_v, vert_shift: vert_shift,
                     sprite_height: sprite_height};

  // shared index unit, reused for every pixel of the span
  tsag_texel_unit #(
    .TEX_BITS(TEX_BITS)
  ) u_texel (
    .cfg  (tex_cfg),
    .kind (kind),
    .u_acc(u_acc),
    .v_acc(v_acc),
    .texel(texel_idx)
  );

  // accumulator and destination stepping per span kind
  always_comb begin
    u_acc_next   = u_acc;
    v_acc_next   = v_acc;
    pix_pos_next = pix_pos;
    unique case (kind)
      OP_HLINE_DESC: begin
        u_acc_next   = u_acc - u_inc;
        v_acc_next   = v_acc - v_inc;
        pix_pos_next = pix_pos - OFS_W'(1);
      end
      OP_HLINE_ASC: begin
        u_acc_next   = u_acc + u_inc;
        v_acc_next   = v_acc + v_inc;
        pix_pos_next = pix_pos + OFS_W'(1);
      end
      OP_VLINE: begin
        v_acc_next   = v_acc + v_inc;
        pix_pos_next = pix_pos + OFS_W'(dest_stride);
      end
      OP_SPRITE: begin
        u_acc_next   = u_acc + u_inc;
        v_acc_next   = v_acc + v_inc;
        pix_pos_next = pix_pos + OFS_W'(dest_stride);
      end
      default: begin
        u_acc_next   = u_acc;
        v_acc_next   = v_acc;
        pix_pos_next = pix_pos;
      end
    endcase
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      pix_left      <= '0;
      log_u         <= LOG_U_RST;
      log_v         <= LOG_V_RST;
      vert_shift    <= VERT_SHIFT_RST;
      sprite_height <= HEIGHT_RST;
      dest_stride   <= STRIDE_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LOG_U:         log_u         <= cfg_value[LOG_W-1:0];
          REG_LOG_V:         log_v         <= cfg_value[LOG_W-1:0];
          REG_VERT_SHIFT:    vert_shift    <= cfg_value[LOG_W-1:0];
          REG_SPRITE_HEIGHT: sprite_height <= cfg_value[HEIGHT_W-1:0];
          REG_DEST_STRIDE:   dest_stride   <= cfg_value[STRIDE_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (start && (start_cnt != '0)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (load && last_pix) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (texel) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      if (start) begin
        pix_left <= start_cnt;
      end else if (load) begin
        pix_left <= pix_left - CNT_W'(1);
      end
    end
  end

  // span payload and output data
  always_ff @(posedge clk) begin
    if (start) begin
      kind    <= span_op_t'(s_tuser);
      u_acc   <= s_tdata[0*ACC_W +: ACC_W];
      v_acc   <= s_tdata[1*ACC_W +: ACC_W];
      u_inc   <= s_tdata[2*ACC_W +: ACC_W];
      v_inc   <= s_tdata[3*ACC_W +: ACC_W];
      pix_pos <= '0;
    end else if (load) begin
      u_acc   <= u_acc_next;
      v_acc   <= v_acc_next;
      pix_pos <= pix_pos_next;
    end

    if (load) begin
      out_texel <= texel_idx;
      out_pos   <= pix_pos;
      out_last  <= last_pix;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_pos, out_texel});
  assign m_tlast  = out_last;

`ifndef SYNTHESIS
  // a running span always has pixels left to send
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (pix_left != '0))
    else $error("span running with no pixels left");

  // sending the final pixel ends the span
  assert property (@(posedge clk) disable iff (rst)
    (load && last_pix) |=> (state == ST_IDLE))
    else $error("span did not end after its final pixel");

  // a zero-pixel span produces nothing
  assert property (@(posedge clk) disable iff (rst)
    (start && (in_cnt == '0)) |=> ((state == ST_IDLE) && !$rose(out_valid)))
    else $error("empty span started work");

  // the output register only fills from a running span
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_RUN))
    else $error("output item appeared outside a span");
`endif

endmodule

@@ verif/span_pixel_checker.sv @@
`timescale 1ns / 1ps

module span_pixel_checker #(
  parameter int TEX_BITS = tsag_pkg::TEX_BITS_DEF,
  parameter int MAX_SPAN = tsag_pkg::MAX_SPAN_DEF,
  parameter int OUT_W    = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tsag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsag_pkg::CFG_DATA_W-1:0] cfg_value,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [tsag_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [tsag_pkg::OP_W-1:0]       s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [OUT_W-1:0]                m_tdata,
  input  logic                            m_tlast,
  output int                              mismatches,
  output int                              pixels_pending
);
  import tsag_pkg::*;

  typedef struct packed {
    logic [TEX_BITS-1:0] texel;
    logic [OFS_W-1:0]    offset;
    logic                last;
  } pixel_t;

  localparam int MAX_PRINTED = 40;

  logic [LOG_W-1:0]    log_u;
  logic [LOG_W-1:0]    log_v;
  logic [LOG_W-1:0]    vert_shift;
  logic [HEIGHT_W-1:0] sprite_height;
  logic [STRIDE_W-1:0] dest_stride;

  pixel_t expected_pixels[$];
  int     fault_count = 0;
  int     pixel_serial = 0;

  task automatic report_mismatch(string msg);
    if (fault_count < MAX_PRINTED) $display("pixel %0d: %s", pixel_serial, msg);
    fault_count++;
  endtask

  function automatic logic [TEX_BITS-1:0] texel_at(span_op_t kind, logic [31:0] ua,
                                                   logic [31:0] va);
    logic [63:0] hu;
    logic [63:0] hv;
    logic [63:0] t;
    case (kind)
      OP_HLINE_DESC, OP_HLINE_ASC: begin
        hu = (log_u == 0) ? 64'd0 : 64'(ua >> (32 - log_u));
        hv = (log_v == 0) ? 64'd0 : 64'(va >> (32 - log_v));
        t  = (hu << log_v) + hv;
      end
      OP_VLINE: begin
        t = 64'(va >> vert_shift);
      end
      default: begin
        // whole parts are the upper halves, sign extended
        hu = {{48{ua[31]}}, ua[31:16]};
        hv = {{48{va[31]}}, va[31:16]};
        t  = hu * 64'(sprite_height) + hv;
      end
    endcase
    return t[TEX_BITS-1:0];
  endfunction

  task automatic predict_span(logic [IN_DATA_W-1:0] d, logic [OP_W-1:0] kind_bits);
    span_op_t       kind;
    logic [31:0]    ua;
    logic [31:0]    va;
    logic [31:0]    du;
    logic [31:0]    dv;
    int             n;
    logic [OFS_W-1:0] pos;
    pixel_t         p;
    kind = span_op_t'(kind_bits);
    ua   = d[31:0];
    va   = d[63:32];
    du   = d[95:64];
    dv   = d[127:96];
    n    = int'(d[134:128]);
    if (n > MAX_SPAN) n = MAX_SPAN;
    pos = '0;
    for (int k = 0; k < n; k++) begin
      p.texel  = texel_at(kind, ua, va);
      p.offset = pos;
      p.last   = (k == n - 1);
      expected_pixels.push_back(p);
      case (kind)
        OP_HLINE_DESC: begin
          ua  = ua - du;
          va  = va - dv;
          pos = pos - OFS_W'(1);
        end
        OP_HLINE_ASC: begin
          ua  = ua + du;
          va  = va + dv;
          pos = pos + OFS_W'(1);
        end
        OP_VLINE: begin
          va  = va + dv;
          pos = pos + OFS_W'(dest_stride);
        end
        default: begin
          ua  = ua + du;
          va  = va + dv;
          pos = pos + OFS_W'(dest_stride);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    logic [TEX_BITS-1:0] got_texel;
    logic [OFS_W-1:0]    got_offset;
    if (rst) begin
      log_u         = LOG_U_RST;
      log_v         = LOG_V_RST;
      vert_shift    = VERT_SHIFT_RST;
      sprite_height = HEIGHT_RST;
      dest_stride   = STRIDE_RST;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LOG_U:         log_u         = cfg_value[LOG_W-1:0];
          REG_LOG_V:         log_v         = cfg_value[LOG_W-1:0];
          REG_VERT_SHIFT:    vert_shift    = cfg_value[LOG_W-1:0];
          REG_SPRITE_HEIGHT: sprite_height = cfg_value[HEIGHT_W-1:0];
          REG_DEST_STRIDE:   dest_stride   = cfg_value[STRIDE_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got_texel  = m_tdata[TEX_BITS-1:0];
        got_offset = m_tdata[TEX_BITS +: OFS_W];
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected item texel %0h offset %0h last %0b",
                                    got_texel, got_offset, m_tlast));
        end else begin
          want = expected_pixels.pop_front();
          if (got_texel !== want.texel)
            report_mismatch($sformatf("texel got %0h want %0h", got_texel, want.texel));
          if (got_offset !== want.offset)
            report_mismatch($sformatf("offset got %0h want %0h", got_offset, want.offset));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", m_tlast, want.last));
        end
        pixel_serial++;
      end
      if (s_tvalid && s_tready) predict_span(s_tdata, s_tuser);
    end
    mismatches     <= fault_count;
    pixels_pending <= expected_pixels.size();
  end

endmodule

@@ verif/textured_span_address_generator_unit_test.sv @@
`timescale 1ns / 1ps

module textured_span_address_generator_unit_test;
  import tsag_pkg::*;

  localparam int TEX_BITS = TEX_BITS_DEF;
  localparam int MAX_SPAN = MAX_SPAN_DEF;
  localparam int OUT_W    = ((TEX_BITS + OFS_W + 7) / 8) * 8;

  localparam int RESET_CYCLES     = 8;
  localparam int N_PHASES         = 8;
  localparam int RANDOM_PER_PHASE = 50;
  localparam int PRESSURE_SPANS   = 12;
  localparam int HOLD_OFF_CYCLES  = 300;
  // a zero-pixel span is taken without leaving idle, so a short settle covers it
  localparam int SETTLE_CYCLES    = 8;
  localparam int TAIL_CYCLES      = 80;
  // worst case: ~450 spans of 64 pixels, each pixel behind the longest receiver stall
  localparam int CYCLE_LIMIT      = 4_000_000;

  typedef struct {
    span_op_t    op;
    logic [31:0] u0;
    logic [31:0] v0;
    logic [31:0] du;
    logic [31:0] dv;
    logic [6:0]  count;
  } span_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_value = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tlast;

  int   mismatches;
  int   pixels_pending;
  int   cycle_count = 0;

  // knobs set by the stimulus for the sender and the receiver
  logic sender_steady = 1'b0;
  logic rx_steady     = 1'b0;
  logic hold_off_req  = 1'b0;

  always #1 clk = ~clk;

  textured_span_address_generator_unit #(
    .TEX_BITS(TEX_BITS),
    .MAX_SPAN(MAX_SPAN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_value(cfg_value),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    // u_start, v_start, u_step, v_step, pixel_count, zero pad
    .s_tdata  (s_tdata),
    // op
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    // texel_index, pixel_offset, zero pad
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  span_pixel_checker #(
    .TEX_BITS(TEX_BITS),
    .MAX_SPAN(MAX_SPAN),
    .OUT_W   (OUT_W)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_value     (cfg_value),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .mismatches    (mismatches),
    .pixels_pending(pixels_pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("textured_span_address_generator_unit: mismatch");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // words biased toward the corners of the accumulators
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0000_0000;
    if (r < 20) return 32'hFFFF_FFFF;
    if (r < 26) return 32'h8000_0000 ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
    if (r < 50) return 32'($urandom_range(0, 65535)) << $urandom_range(8, 20);
    if (r < 60) return -(32'($urandom_range(0, 65535)) << $urandom_range(8, 20));
    return $urandom;
  endfunction

  // pixel counts: mostly short spans, some empty, some at or above the cap
  function automatic logic [6:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 7'd0;
    if (r < 15) return 7'($urandom_range(65, 127));
    if (r < 22) return 7'd64;
    if (r < 32) return 7'd1;
    return 7'($urandom_range(2, 16));
  endfunction

  function automatic span_cmd_t mk_span(span_op_t op, logic [31:0] u0, logic [31:0] v0,
                                        logic [31:0] du, logic [31:0] dv, logic [6:0] n);
    span_cmd_t s;
    s.op    = op;
    s.u0    = u0;
    s.v0    = v0;
    s.du    = du;
    s.dv    = dv;
    s.count = n;
    return s;
  endfunction

  function automatic span_cmd_t random_span();
    return mk_span(span_op_t'($urandom_range(0, 3)), pick_word(), pick_word(),
                   pick_word(), pick_word(), pick_count());
  endfunction

  // offer one span and hold it until the block takes it
  task automatic push_span(span_cmd_t s);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= s.op;
    s_tdata  <= {1'b0, s.count, s.dv, s.du, s.v0, s.u0};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering and wait for every pending pixel, then let the block settle
  task automatic drain_pixels();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pixels_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_value <= value;
    @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_settings(logic [4:0] lu, logic [4:0] lv, logic [4:0] vs,
                                logic [11:0] h, logic [15:0] st);
    write_reg(REG_LOG_U, 16'(lu));
    write_reg(REG_LOG_V, 16'(lv));
    write_reg(REG_VERT_SHIFT, 16'(vs));
    write_reg(REG_SPRITE_HEIGHT, 16'(h));
    write_reg(REG_DEST_STRIDE, st);
    cfg_we <= 1'b0;
  endtask

  // receiver: random ready with stalls, steady stretches, and one long hold-off
  initial begin : receiver
    int run_len;
    int stall_len;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (rx_steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        run_len = $urandom_range(1, 12);
        m_tready <= 1'b1;
        repeat (run_len) @(posedge clk);
        stall_len = pick_gap();
        if (stall_len > 0) begin
          m_tready <= 1'b0;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed spans at the reset settings
    push_span(mk_span(OP_HLINE_DESC, 32'h0, 32'h0, 32'h0400_0000, 32'h0400_0000, 7'd5));
    push_span(mk_span(OP_HLINE_ASC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 7'd64));
    push_span(mk_span(OP_VLINE, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0100_0000, 7'd3));
    push_span(mk_span(OP_SPRITE, 32'h8000_0000, 32'hFFFF_0000, 32'h0001_0000,
                      32'h0001_0000, 7'd10));
    // empty spans of every kind produce nothing
    push_span(mk_span(OP_HLINE_DESC, 32'h1234_5678, 32'h9ABC_DEF0, 32'h1, 32'h1, 7'd0));
    push_span(mk_span(OP_HLINE_ASC, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 7'd0));
    push_span(mk_span(OP_VLINE, 32'h0, 32'h0, 32'h0, 32'h0, 7'd0));
    push_span(mk_span(OP_SPRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 7'd0));
    // counts at the cap and above it, which saturate
    push_span(mk_span(OP_HLINE_ASC, 32'h0, 32'h0, 32'h0100_0000, 32'h0080_0000, 7'd127));
    push_span(mk_span(OP_SPRITE, 32'h7FFF_FFFF, 32'h7FFF_0000, 32'hFFFF_0000,
                      32'h0002_0000, 7'd65));
    push_span(mk_span(OP_HLINE_DESC, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 7'd64));
    push_span(mk_span(OP_VLINE, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 7'd127));
    // single pixel spans
    push_span(mk_span(OP_HLINE_DESC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 7'd1));
    push_span(mk_span(OP_HLINE_ASC, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 7'd1));
    push_span(mk_span(OP_VLINE, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 7'd1));
    push_span(mk_span(OP_SPRITE, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 7'd1));
    drain_pixels();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        // zero sizes: no hline contribution, bare v in sprites, vline and sprite offsets zero
        0: write_settings(5'd0, 5'd0, 5'd0, 12'd0, 16'd0);
        // every field at its top value, hline sum wraps
        1: write_settings(5'd31, 5'd31, 5'd31, 12'hFFF, 16'hFFFF);
        2: write_settings(5'd16, 5'd16, 5'd16, 12'd1, 16'd1);
        3: write_settings(5'd1, 5'd16, 5'd0, 12'hFFF, 16'd320);
        default: write_settings(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                                5'($urandom_range(0, 31)), 12'($urandom_range(0, 4095)),
                                16'($urandom_range(0, 65535)));
      endcase
      sender_steady = (ph == 3 || ph == 6);
      rx_steady     = (ph == 5 || ph == 6);

      if (ph == 2) begin
        // receiver holds off while full spans keep coming, so the input stalls
        hold_off_req = 1'b1;
        repeat (PRESSURE_SPANS)
          push_span(mk_span(span_op_t'($urandom_range(0, 3)), $urandom, $urandom,
                            pick_word(), pick_word(), 7'd64));
      end

      repeat (RANDOM_PER_PHASE) push_span(random_span());
      drain_pixels();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pixels_pending == 0) begin
      $display("textured_span_address_generator_unit: match");
    end else begin
      $display("textured_span_address_generator_unit: mismatch");
    end
    $finish;
  end

endmodule
